FILE: design/rsld_pkg.sv
// Shared types and constants of the run-length sprite line decoder.
package rsld_pkg;

   // Default width of the destination offset counter
   localparam int OFFSET_BITS_DEFAULT = 16;

   // Fixed field widths
   localparam int BYTE_BITS   = 8;
   localparam int OFS_PORT_BITS = 16;
   localparam int RUN_BITS    = 7;
   localparam int LEN_BITS    = 16;

   // Opcodes of the first byte of a line
   localparam logic [BYTE_BITS-1:0] OP_LITERAL  = 8'd0;
   localparam logic [BYTE_BITS-1:0] OP_FILL     = 8'd1;
   localparam logic [BYTE_BITS-1:0] OP_SKIP     = 8'd2;
   localparam logic [BYTE_BITS-1:0] OP_OFFSET   = 8'd3;
   localparam logic [BYTE_BITS-1:0] OP_EMPTY    = 8'd4;
   localparam logic [BYTE_BITS-1:0] OP_SKIP_HDR = 8'd7;
   localparam logic [BYTE_BITS-1:0] OP_OFS_HDR  = 8'd8;

   // Gap byte that terminates an offset-mode line
   localparam logic [BYTE_BITS-1:0] GAP_END = 8'hFF;

   typedef enum logic [3:0] {
      PH_OPCODE,
      PH_COPY,
      PH_IGN1,
      PH_IGN2,
      PH_LEAD,
      PH_COUNT,
      PH_LIT,
      PH_FILL,
      PH_GAP
   } phase_type;

   typedef enum logic [1:0] {
      MODE_LIT,
      MODE_FILL,
      MODE_SKIP,
      MODE_OFS
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK,
      ST_BAD_OPCODE,
      ST_SATURATED
   } status_type;

   typedef struct packed {
      logic [OFS_PORT_BITS-1:0] write_offset;
      logic [RUN_BITS-1:0]      run_length;
      logic [BYTE_BITS-1:0]     pixel_value;
      logic                     line_done;
      status_type               status;
   } result_type;

   // Occupancy of the output buffer
   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } buf_state_type;

endpackage

FILE: design/rsld_if.sv
// Channel interfaces: encoded byte input, write command output, register write.
interface rsld_req_if;
   logic                          valid;
   logic                          ready;
   logic [rsld_pkg::BYTE_BITS-1:0] stream_byte;

   modport source (output valid, output stream_byte, input ready);
   modport sink   (input valid, input stream_byte, output ready);
endinterface

interface rsld_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rsld_pkg::OFS_PORT_BITS-1:0] write_offset;
   logic [rsld_pkg::RUN_BITS-1:0]      run_length;
   logic [rsld_pkg::BYTE_BITS-1:0]     pixel_value;
   logic                              line_done;
   logic [1:0]                        status;

   modport source (output valid, output write_offset, output run_length,
                   output pixel_value, output line_done, output status,
                   input ready);
   modport sink   (input valid, input write_offset, input run_length,
                   input pixel_value, input line_done, input status,
                   output ready);
endinterface

interface rsld_csr_if;
   logic                         valid;
   logic                         ready;
   logic [rsld_pkg::LEN_BITS-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: design/rsld_decoder.sv
// Line decoder: phase state machine, offset tracking and result formation.
module rsld_decoder #(
   parameter int OFFSET_BITS = rsld_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [rsld_pkg::BYTE_BITS-1:0] stream_byte,
   input  logic [rsld_pkg::LEN_BITS-1:0]  line_len,
   output logic                          res_valid,
   output rsld_pkg::result_type          res
);

   localparam int EXT_BITS = (OFFSET_BITS > rsld_pkg::OFS_PORT_BITS) ?
                             OFFSET_BITS : rsld_pkg::OFS_PORT_BITS;

   rsld_pkg::phase_type              phase_ff, phase_in;
   rsld_pkg::mode_type               mode_ff, mode_in;
   logic [rsld_pkg::LEN_BITS-1:0]    left_ff, left_in;
   logic [OFFSET_BITS-1:0]           dest_ff, dest_in;

   logic [rsld_pkg::BYTE_BITS-1:0]   adv_amt;
   logic [OFFSET_BITS:0]             adv_sum;
   logic                             adv_carry;
   logic [OFFSET_BITS-1:0]           adv_dest;
   logic [rsld_pkg::RUN_BITS-1:0]    run_req;
   logic [OFFSET_BITS:0]             room;
   logic                             clip;
   logic [rsld_pkg::RUN_BITS-1:0]    fill_len;
   logic [rsld_pkg::LEN_BITS-1:0]    left_dec;
   logic [rsld_pkg::LEN_BITS-1:0]    lit_count;
   rsld_pkg::phase_type              after_run;
   logic [OFFSET_BITS-1:0]           ofs_sel;
   logic [EXT_BITS-1:0]              ofs_ext;

   // Shared offset advance with saturation
   assign run_req   = left_ff[rsld_pkg::RUN_BITS-1:0];
   assign adv_amt   = (phase_ff == rsld_pkg::PH_FILL) ?
                      rsld_pkg::BYTE_BITS'(run_req) :
                      ((phase_ff == rsld_pkg::PH_COPY || phase_ff == rsld_pkg::PH_LIT) ?
                       rsld_pkg::BYTE_BITS'(1) : stream_byte);
   assign adv_sum   = {1'b0, dest_ff} + (OFFSET_BITS+1)'(adv_amt);
   assign adv_carry = adv_sum[OFFSET_BITS];
   assign adv_dest  = adv_carry ? '1 : adv_sum[OFFSET_BITS-1:0];

   // Fill clipping against the room left up to the top offset
   assign room      = {1'b0, ~dest_ff} + (OFFSET_BITS+1)'(1);
   assign clip      = (OFFSET_BITS+1)'(run_req) > room;
   assign fill_len  = clip ? room[rsld_pkg::RUN_BITS-1:0] : run_req;

   assign left_dec  = left_ff - rsld_pkg::LEN_BITS'(1);
   // Negative count: two's complement magnitude, 128 for 0x80
   assign lit_count = rsld_pkg::LEN_BITS'(8'(~stream_byte + 8'd1));
   assign after_run = (mode_ff == rsld_pkg::MODE_OFS) ? rsld_pkg::PH_GAP :
                                                        rsld_pkg::PH_COUNT;

   // Next state
   always_comb begin
      phase_in = phase_ff;
      mode_in  = mode_ff;
      left_in  = left_ff;
      dest_in  = dest_ff;
      if (take) begin
         case (phase_ff)
            rsld_pkg::PH_COPY, rsld_pkg::PH_LIT: begin
               dest_in = adv_dest;
               left_in = left_dec;
               if (left_dec == '0) begin
                  phase_in = (phase_ff == rsld_pkg::PH_COPY) ? rsld_pkg::PH_OPCODE :
                                                                after_run;
               end
            end
            rsld_pkg::PH_IGN1: phase_in = rsld_pkg::PH_IGN2;
            rsld_pkg::PH_IGN2: begin
               phase_in = (mode_ff == rsld_pkg::MODE_OFS) ? rsld_pkg::PH_LEAD :
                                                            rsld_pkg::PH_COUNT;
            end
            rsld_pkg::PH_LEAD: begin
               phase_in = rsld_pkg::PH_COUNT;
               dest_in  = adv_dest;
            end
            rsld_pkg::PH_COUNT: begin
               if (stream_byte == '0) begin
                  phase_in = (mode_ff == rsld_pkg::MODE_OFS) ? rsld_pkg::PH_GAP :
                                                               rsld_pkg::PH_OPCODE;
               end else if (stream_byte[rsld_pkg::BYTE_BITS-1]) begin
                  left_in  = lit_count;
                  phase_in = rsld_pkg::PH_LIT;
               end else if (mode_ff == rsld_pkg::MODE_SKIP) begin
                  dest_in = adv_dest;
               end else begin
                  left_in  = rsld_pkg::LEN_BITS'(stream_byte);
                  phase_in = rsld_pkg::PH_FILL;
               end
            end
            rsld_pkg::PH_FILL: begin
               dest_in  = adv_dest;
               left_in  = '0;
               phase_in = after_run;
            end
            rsld_pkg::PH_GAP: begin
               if (stream_byte == rsld_pkg::GAP_END) begin
                  phase_in = rsld_pkg::PH_OPCODE;
               end else begin
                  phase_in = rsld_pkg::PH_COUNT;
                  dest_in  = adv_dest;
               end
            end
            default: begin
               // opcode byte starts a new line at offset zero
               phase_in = rsld_pkg::PH_OPCODE;
               dest_in  = '0;
               left_in  = '0;
               case (stream_byte)
                  rsld_pkg::OP_LITERAL: begin
                     mode_in = rsld_pkg::MODE_LIT;
                     left_in = line_len;
                     if (line_len != '0) begin
                        phase_in = rsld_pkg::PH_COPY;
                     end
                  end
                  rsld_pkg::OP_FILL: begin
                     mode_in  = rsld_pkg::MODE_FILL;
                     phase_in = rsld_pkg::PH_COUNT;
                  end
                  rsld_pkg::OP_SKIP: begin
                     mode_in  = rsld_pkg::MODE_SKIP;
                     phase_in = rsld_pkg::PH_COUNT;
                  end
                  rsld_pkg::OP_OFFSET: begin
                     mode_in  = rsld_pkg::MODE_OFS;
                     phase_in = rsld_pkg::PH_LEAD;
                  end
                  rsld_pkg::OP_EMPTY: mode_in = rsld_pkg::MODE_LIT;
                  rsld_pkg::OP_SKIP_HDR: begin
                     mode_in  = rsld_pkg::MODE_SKIP;
                     phase_in = rsld_pkg::PH_IGN1;
                  end
                  rsld_pkg::OP_OFS_HDR: begin
                     mode_in  = rsld_pkg::MODE_OFS;
                     phase_in = rsld_pkg::PH_IGN1;
                  end
                  default: ;
               endcase
            end
         endcase
      end
   end

   // Result of the current byte
   always_comb begin
      res_valid       = 1'b0;
      ofs_sel         = dest_ff;
      res.run_length  = '0;
      res.pixel_value = '0;
      res.line_done   = 1'b0;
      res.status      = rsld_pkg::ST_OK;
      case (phase_ff)
         rsld_pkg::PH_COPY, rsld_pkg::PH_LIT: begin
            res_valid       = 1'b1;
            res.run_length  = rsld_pkg::RUN_BITS'(1);
            res.pixel_value = stream_byte;
            res.line_done   = (phase_ff == rsld_pkg::PH_COPY) && (left_dec == '0);
            res.status      = adv_carry ? rsld_pkg::ST_SATURATED : rsld_pkg::ST_OK;
         end
         rsld_pkg::PH_IGN1, rsld_pkg::PH_IGN2: ;
         rsld_pkg::PH_LEAD: begin
            if (adv_carry) begin
               res_valid  = 1'b1;
               ofs_sel    = adv_dest;
               res.status = rsld_pkg::ST_SATURATED;
            end
         end
         rsld_pkg::PH_COUNT: begin
            if (stream_byte == '0) begin
               if (mode_ff != rsld_pkg::MODE_OFS) begin
                  res_valid     = 1'b1;
                  res.line_done = 1'b1;
               end
            end else if (!stream_byte[rsld_pkg::BYTE_BITS-1] &&
                         mode_ff == rsld_pkg::MODE_SKIP && adv_carry) begin
               res_valid  = 1'b1;
               ofs_sel    = adv_dest;
               res.status = rsld_pkg::ST_SATURATED;
            end
         end
         rsld_pkg::PH_FILL: begin
            res_valid       = 1'b1;
            res.run_length  = fill_len;
            res.pixel_value = stream_byte;
            res.status      = adv_carry ? rsld_pkg::ST_SATURATED : rsld_pkg::ST_OK;
         end
         rsld_pkg::PH_GAP: begin
            if (stream_byte == rsld_pkg::GAP_END) begin
               res_valid     = 1'b1;
               res.line_done = 1'b1;
            end else if (adv_carry) begin
               res_valid  = 1'b1;
               ofs_sel    = adv_dest;
               res.status = rsld_pkg::ST_SATURATED;
            end
         end
         default: begin
            ofs_sel = '0;
            case (stream_byte)
               rsld_pkg::OP_LITERAL: begin
                  if (line_len == '0) begin
                     res_valid     = 1'b1;
                     res.line_done = 1'b1;
                  end
               end
               rsld_pkg::OP_EMPTY: begin
                  res_valid     = 1'b1;
                  res.line_done = 1'b1;
               end
               rsld_pkg::OP_FILL, rsld_pkg::OP_SKIP, rsld_pkg::OP_OFFSET,
               rsld_pkg::OP_SKIP_HDR, rsld_pkg::OP_OFS_HDR: ;
               default: begin
                  res_valid     = 1'b1;
                  res.line_done = 1'b1;
                  res.status    = rsld_pkg::ST_BAD_OPCODE;
               end
            endcase
         end
      endcase
      res_valid = res_valid & take;

      // Offset shown on the port is the low part of the counter
      ofs_ext          = EXT_BITS'(ofs_sel);
      res.write_offset = ofs_ext[rsld_pkg::OFS_PORT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rsld_pkg::PH_OPCODE;
         mode_ff  <= rsld_pkg::MODE_LIT;
         left_ff  <= '0;
         dest_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         mode_ff  <= mode_in;
         left_ff  <= left_in;
         dest_ff  <= dest_in;
      end
   end

endmodule

FILE: design/rsld_outbuf.sv
// Two-entry output register with skid stage for write command results.
module rsld_outbuf (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rsld_pkg::result_type    push_data,
   output logic                    in_ready,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rsld_pkg::result_type    out_data,
   output rsld_pkg::buf_state_type occ
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   rsld_pkg::result_type main_ff, main_in;
   rsld_pkg::result_type skid_ff, skid_in;
   logic                 pop;

   assign pop       = main_valid_ff & out_ready;
   assign in_ready  = ~skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign occ       = '{main_valid: main_valid_ff, skid_valid: skid_valid_ff};

   // Fill main first, spill into skid when main is held
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: design/rle_sprite_line_decoder.sv
// Top level of the run-length sprite line decoder.
//
//   channel   | role   | beat carries
//   ----------+--------+------------------------------------------------------
//   req_bus   | sink   | stream_byte: next encoded byte of the line, opcode first
//   rsp_bus   | source | write_offset, run_length, pixel_value, line_done, status
//   csr_bus   | sink   | data: literal_line_length, always ready
//
// One byte is decoded per cycle while input is not stalled; the phase update and
// a single offset adder sit between the state registers and the output
// register, which holds each result. Reset (synchronous, active high) clears the
// phase, offset, count and the register. A two-entry output buffer keeps input
// open while one result waits; input stalls only when both entries are held.
module rle_sprite_line_decoder #(
   parameter int OFFSET_BITS = rsld_pkg::OFFSET_BITS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   rsld_req_if.sink         req_bus,
   rsld_rsp_if.source       rsp_bus,
   rsld_csr_if.sink         csr_bus
);

   logic [rsld_pkg::LEN_BITS-1:0] line_len_ff;
   logic                          take;
   logic                          res_valid;
   rsld_pkg::result_type          res;
   rsld_pkg::result_type          out_data;
   logic                          in_ready;
   rsld_pkg::buf_state_type       occ;

   // Configuration register
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_len_ff <= '0;
      end else if (csr_bus.valid) begin
         line_len_ff <= csr_bus.data;
      end
   end

   assign req_bus.ready = in_ready;
   assign take          = req_bus.valid & in_ready;

   rsld_decoder #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_decoder (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .stream_byte (req_bus.stream_byte),
      .line_len    (line_len_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   rsld_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .in_ready  (in_ready),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_data  (out_data),
      .occ       (occ)
   );

   assign rsp_bus.write_offset = out_data.write_offset;
   assign rsp_bus.run_length   = out_data.run_length;
   assign rsp_bus.pixel_value  = out_data.pixel_value;
   assign rsp_bus.line_done    = out_data.line_done;
   assign rsp_bus.status       = out_data.status;

`ifndef SYNTHESIS
   // Skid entry only fills behind a held main entry
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      occ.skid_valid |-> occ.main_valid)
      else $error("skid entry valid while main entry empty");

   // Unknown opcode always closes the line without a write
   a_bad_opcode_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == rsld_pkg::ST_BAD_OPCODE) |->
      (rsp_bus.line_done && rsp_bus.run_length == '0))
      else $error("unknown opcode result malformed");

   // Beats that write nothing carry a zero value
   a_no_write_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.run_length == '0) |-> (rsp_bus.pixel_value == '0))
      else $error("empty write carries a pixel value");

   // A full buffer with a stalled output stays full
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (occ.skid_valid && !rsp_bus.ready) |=> occ.skid_valid)
      else $error("skid entry lost under stall");
`endif

endmodule

FILE: verif/rle_sprite_line_decoder_tb.sv
// Self-checking testbench for the run-length sprite line decoder.
`timescale 1ns / 1ps

module rle_sprite_line_decoder_tb;

   localparam int        OFS_BITS     = rsld_pkg::OFFSET_BITS_DEFAULT;
   localparam bit [39:0] OFS_TOP      = (40'd1 << OFS_BITS) - 40'd1;
   // Run limit for a full pass; allow far more than it needs
   localparam int        CYCLE_LIMIT  = 200_000;
   localparam int        DRAIN_CYCLES = 200;
   localparam int        QUIET_CYCLES = 8;
   localparam int        PHASE_BYTES  = 14;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsld_req_if req_bus ();
   rsld_rsp_if rsp_bus ();
   rsld_csr_if csr_bus ();

   rle_sprite_line_decoder #(.OFFSET_BITS(OFS_BITS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Decoder model state and its copy of the line length register
   rsld_pkg::phase_type  dec_phase = rsld_pkg::PH_OPCODE;
   rsld_pkg::mode_type   dec_mode  = rsld_pkg::MODE_LIT;
   bit [15:0]            run_left  = '0;
   bit [39:0]            next_ofs  = '0;
   bit [15:0]            copy_len  = '0;

   bit [7:0]             byte_q[$];        // encoded bytes waiting to be driven
   bit [7:0]             line_buf[$];      // line under construction
   rsld_pkg::result_type pending_cmds[$];  // write commands still owed by the block
   int                   bytes_queued = 0;
   int                   stall_pct    = 14;
   int                   err_count    = 0;
   longint               cycle_count  = 0;

   // Clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Move the offset forward, pinning it at the ceiling; 1 when it pinned
   function automatic bit bump_ofs(input bit [39:0] n);
      bit [39:0] sum;
      sum = next_ofs + n;
      if (sum > OFS_TOP) begin
         next_ofs = OFS_TOP;
         return 1'b1;
      end
      next_ofs = sum;
      return 1'b0;
   endfunction

   function automatic rsld_pkg::result_type make_cmd(input bit [39:0] ofs,
                                                     input bit [6:0] len,
                                                     input bit [7:0] val, input bit done,
                                                     input rsld_pkg::status_type st);
      rsld_pkg::result_type r;
      r.write_offset = ofs[rsld_pkg::OFS_PORT_BITS-1:0];
      r.run_length   = len;
      r.pixel_value  = val;
      r.line_done    = done;
      r.status       = st;
      return r;
   endfunction

   function automatic rsld_pkg::result_type close_line();
      dec_phase = rsld_pkg::PH_OPCODE;
      return make_cmd(next_ofs, 7'd0, 8'd0, 1'b1, rsld_pkg::ST_OK);
   endfunction

   // Decode one byte; returns 1 when the byte yields a write command
   function automatic bit decode_byte(input bit [7:0] b, output rsld_pkg::result_type cmd);
      bit [39:0] start;
      bit [39:0] fill_len;
      bit [39:0] room;
      bit        sat;
      bit        clip;
      start = next_ofs;
      cmd   = '0;
      case (dec_phase)
         rsld_pkg::PH_COPY, rsld_pkg::PH_LIT: begin
            sat = bump_ofs(40'd1);
            run_left = run_left - 16'd1;
            cmd = make_cmd(start, 7'd1, b, 1'b0,
                           sat ? rsld_pkg::ST_SATURATED : rsld_pkg::ST_OK);
            if (run_left == 16'd0) begin
               if (dec_phase == rsld_pkg::PH_COPY) begin
                  dec_phase = rsld_pkg::PH_OPCODE;
                  cmd.line_done = 1'b1;
               end else begin
                  dec_phase = (dec_mode == rsld_pkg::MODE_OFS) ? rsld_pkg::PH_GAP :
                                                                 rsld_pkg::PH_COUNT;
               end
            end
            return 1'b1;
         end
         rsld_pkg::PH_IGN1: begin
            dec_phase = rsld_pkg::PH_IGN2;
            return 1'b0;
         end
         rsld_pkg::PH_IGN2: begin
            dec_phase = (dec_mode == rsld_pkg::MODE_OFS) ? rsld_pkg::PH_LEAD :
                                                           rsld_pkg::PH_COUNT;
            return 1'b0;
         end
         rsld_pkg::PH_LEAD: begin
            dec_phase = rsld_pkg::PH_COUNT;
            if (bump_ofs(40'(b))) begin
               cmd = make_cmd(next_ofs, 7'd0, 8'd0, 1'b0, rsld_pkg::ST_SATURATED);
               return 1'b1;
            end
            return 1'b0;
         end
         rsld_pkg::PH_COUNT: begin
            // zero ends the line, except in offset mode where a gap follows
            if (b == 8'd0) begin
               if (dec_mode == rsld_pkg::MODE_OFS) begin
                  dec_phase = rsld_pkg::PH_GAP;
                  return 1'b0;
               end
               cmd = close_line();
               return 1'b1;
            end
            // negative count: literal run of -count bytes
            if (b[7]) begin
               run_left = 16'd256 - 16'(b);
               dec_phase = rsld_pkg::PH_LIT;
               return 1'b0;
            end
            // positive count: transparent skip or fill run
            if (dec_mode == rsld_pkg::MODE_SKIP) begin
               if (bump_ofs(40'(b))) begin
                  cmd = make_cmd(next_ofs, 7'd0, 8'd0, 1'b0, rsld_pkg::ST_SATURATED);
                  return 1'b1;
               end
               return 1'b0;
            end
            run_left = 16'(b);
            dec_phase = rsld_pkg::PH_FILL;
            return 1'b0;
         end
         rsld_pkg::PH_FILL: begin
            // fill clipped so that it ends at the ceiling
            fill_len = 40'(run_left[6:0]);
            room = OFS_TOP - start + 40'd1;
            clip = fill_len > room;
            if (clip) fill_len = room;
            sat = bump_ofs(fill_len);
            run_left = 16'd0;
            dec_phase = (dec_mode == rsld_pkg::MODE_OFS) ? rsld_pkg::PH_GAP :
                                                           rsld_pkg::PH_COUNT;
            cmd = make_cmd(start, fill_len[6:0], b, 1'b0,
                           (sat || clip) ? rsld_pkg::ST_SATURATED : rsld_pkg::ST_OK);
            return 1'b1;
         end
         rsld_pkg::PH_GAP: begin
            if (b == rsld_pkg::GAP_END) begin
               cmd = close_line();
               return 1'b1;
            end
            dec_phase = rsld_pkg::PH_COUNT;
            if (bump_ofs(40'(b))) begin
               cmd = make_cmd(next_ofs, 7'd0, 8'd0, 1'b0, rsld_pkg::ST_SATURATED);
               return 1'b1;
            end
            return 1'b0;
         end
         default: begin
            // opcode byte starts a new line at offset zero
            dec_phase = rsld_pkg::PH_OPCODE;
            next_ofs  = '0;
            run_left  = '0;
            case (b)
               rsld_pkg::OP_LITERAL: begin
                  dec_mode = rsld_pkg::MODE_LIT;
                  run_left = copy_len;
                  if (copy_len == 16'd0) begin
                     cmd = close_line();
                     return 1'b1;
                  end
                  dec_phase = rsld_pkg::PH_COPY;
               end
               rsld_pkg::OP_FILL: begin
                  dec_mode  = rsld_pkg::MODE_FILL;
                  dec_phase = rsld_pkg::PH_COUNT;
               end
               rsld_pkg::OP_SKIP: begin
                  dec_mode  = rsld_pkg::MODE_SKIP;
                  dec_phase = rsld_pkg::PH_COUNT;
               end
               rsld_pkg::OP_OFFSET: begin
                  dec_mode  = rsld_pkg::MODE_OFS;
                  dec_phase = rsld_pkg::PH_LEAD;
               end
               rsld_pkg::OP_EMPTY: begin
                  dec_mode = rsld_pkg::MODE_LIT;
                  cmd = close_line();
                  return 1'b1;
               end
               rsld_pkg::OP_SKIP_HDR: begin
                  dec_mode  = rsld_pkg::MODE_SKIP;
                  dec_phase = rsld_pkg::PH_IGN1;
               end
               rsld_pkg::OP_OFS_HDR: begin
                  dec_mode  = rsld_pkg::MODE_OFS;
                  dec_phase = rsld_pkg::PH_IGN1;
               end
               default: begin
                  cmd = make_cmd(40'd0, 7'd0, 8'd0, 1'b1, rsld_pkg::ST_BAD_OPCODE);
                  return 1'b1;
               end
            endcase
            return 1'b0;
         end
      endcase
      return 1'b0;
   endfunction

   // Runs of one line in the given mode, closed by its end marker
   task automatic add_body(input rsld_pkg::mode_type m, input int nruns);
      int pick;
      int len;
      for (int i = 0; i < nruns; i++) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            // literal run: mostly short, now and then up to the full 128
            pick = $urandom_range(19);
            len = (pick == 0) ? 128 : (pick < 4) ? $urandom_range(1, 128)
                                                 : $urandom_range(1, 8);
            line_buf.push_back(8'(256 - len));
            repeat (len) line_buf.push_back(8'($urandom));
         end else if (pick >= 90 && m == rsld_pkg::MODE_OFS) begin
            line_buf.push_back(8'd0);  // no run, straight to the gap
         end else begin
            len = ($urandom_range(3) == 0) ? 127 : $urandom_range(1, 127);
            line_buf.push_back(8'(len));
            if (m != rsld_pkg::MODE_SKIP) line_buf.push_back(8'($urandom));
         end
         if (m == rsld_pkg::MODE_OFS)
            line_buf.push_back((i == nruns - 1) ? rsld_pkg::GAP_END :
                                                  8'($urandom_range(0, 254)));
      end
      if (m != rsld_pkg::MODE_OFS) line_buf.push_back(8'd0);
   endtask

   // One random scanline of any kind, or a short burst of noise
   task automatic build_line();
      int       pick;
      bit [7:0] op;
      line_buf.delete();
      pick = $urandom_range(92);
      if (pick < 10) begin
         line_buf.push_back(rsld_pkg::OP_LITERAL);
         repeat (copy_len) line_buf.push_back(8'($urandom));
      end else if (pick < 30) begin
         line_buf.push_back(rsld_pkg::OP_FILL);
         add_body(rsld_pkg::MODE_FILL, $urandom_range(1, 4));
      end else if (pick < 45) begin
         line_buf.push_back(rsld_pkg::OP_SKIP);
         add_body(rsld_pkg::MODE_SKIP, $urandom_range(1, 4));
      end else if (pick < 60) begin
         line_buf = '{rsld_pkg::OP_OFFSET, 8'($urandom)};
         add_body(rsld_pkg::MODE_OFS, $urandom_range(1, 4));
      end else if (pick < 65) begin
         line_buf.push_back(rsld_pkg::OP_EMPTY);
      end else if (pick < 73) begin
         line_buf = '{rsld_pkg::OP_SKIP_HDR, 8'($urandom), 8'($urandom)};
         add_body(rsld_pkg::MODE_SKIP, $urandom_range(1, 4));
      end else if (pick < 81) begin
         line_buf = '{rsld_pkg::OP_OFS_HDR, 8'($urandom), 8'($urandom), 8'($urandom)};
         add_body(rsld_pkg::MODE_OFS, $urandom_range(1, 4));
      end else if (pick < 87) begin
         do op = 8'($urandom_range(5, 255));
         while (op == rsld_pkg::OP_SKIP_HDR || op == rsld_pkg::OP_OFS_HDR);
         line_buf.push_back(op);
      end else begin
         repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom));
      end
   endtask

   // Line that walks the offset close to its ceiling, then runs into it
   task automatic build_deep_line(input bit ofs_mode);
      longint   reach;
      bit [7:0] step;
      line_buf.delete();
      if (ofs_mode) begin
         if ($urandom_range(1) == 1)
            line_buf = '{rsld_pkg::OP_OFS_HDR, 8'($urandom), 8'($urandom)};
         else line_buf.push_back(rsld_pkg::OP_OFFSET);
         step = 8'($urandom);
         line_buf.push_back(step);  // leading skip
         reach = step;
      end else begin
         if ($urandom_range(1) == 1)
            line_buf = '{rsld_pkg::OP_SKIP_HDR, 8'($urandom), 8'($urandom)};
         else line_buf.push_back(rsld_pkg::OP_SKIP);
         reach = 0;
      end
      while (reach < OFS_TOP - 300) begin
         if (ofs_mode) begin
            step = 8'($urandom_range(240, 254));
            line_buf.push_back(8'd0);  // empty count, then a wide gap
            line_buf.push_back(step);
         end else begin
            step = 8'd127;
            line_buf.push_back(step);
         end
         reach += step;
      end
      add_body(ofs_mode ? rsld_pkg::MODE_OFS : rsld_pkg::MODE_SKIP, 6);
   endtask

   // Hand the built line to the driver, optionally cut short
   task automatic queue_line(input bit truncate);
      int keep;
      keep = line_buf.size();
      if (truncate && keep > 1) keep = $urandom_range(1, keep - 1);
      for (int i = 0; i < keep; i++) byte_q.push_back(line_buf[i]);
      bytes_queued += keep;
   endtask

   // Wait until every byte is taken and every write command is back
   task automatic settle();
      int waited;
      do @(negedge clock); while (byte_q.size() != 0 || req_bus.valid);
      waited = 0;
      while (pending_cmds.size() != 0 && waited < DRAIN_CYCLES) begin
         @(posedge clock);
         waited++;
      end
      if (pending_cmds.size() != 0) begin
         $error("%0d write commands never arrived", pending_cmds.size());
         err_count++;
         pending_cmds.delete();
      end
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endtask

   // Byte driver; the model advances on every accepted beat
   always @(posedge clock) begin : byte_driver
      rsld_pkg::result_type cmd;
      if (reset) begin
         req_bus.valid       <= 1'b0;
         req_bus.stream_byte <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (decode_byte(req_bus.stream_byte, cmd)) pending_cmds.push_back(cmd);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= stall_pct) begin
               req_bus.valid       <= 1'b1;
               req_bus.stream_byte <= byte_q.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Write command monitor with random back-pressure
   always @(posedge clock) begin : cmd_monitor
      rsld_pkg::result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_cmds.size() == 0) begin
               $error("unexpected write command at offset %0d", rsp_bus.write_offset);
               err_count++;
            end else begin
               want = pending_cmds.pop_front();
               check_field("write_offset", want.write_offset, rsp_bus.write_offset);
               check_field("run_length", want.run_length, rsp_bus.run_length);
               check_field("pixel_value", want.pixel_value, rsp_bus.pixel_value);
               check_field("line_done", want.line_done, rsp_bus.line_done);
               check_field("status", want.status, rsp_bus.status);
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      bit [15:0] settings[5];
      int        base;
      req_bus.valid       = 1'b0;
      req_bus.stream_byte = '0;
      rsp_bus.ready       = 1'b0;
      csr_bus.valid       = 1'b0;
      csr_bus.data        = '0;
      settings = '{16'd1, 16'd0, 16'd3, 16'd16, 16'($urandom_range(2, 40))};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed lines at the reset line length of zero
      line_buf = '{rsld_pkg::OP_EMPTY,
                   rsld_pkg::OP_LITERAL,                          // empty literal line
                   8'hFF,                                         // unknown opcode
                   rsld_pkg::OP_FILL, 8'hFF, 8'h00, 8'h7F, 8'hFF, 8'h00,
                   rsld_pkg::OP_SKIP, 8'h7F, 8'hFE, 8'hA5, 8'h5A, 8'h00,
                   rsld_pkg::OP_OFFSET, 8'hFF, 8'h02, 8'h55, 8'h00, 8'h00,
                   rsld_pkg::GAP_END,
                   rsld_pkg::OP_SKIP_HDR, 8'hFF, 8'h00, 8'h00,
                   rsld_pkg::OP_OFS_HDR, 8'h00, 8'hFF, 8'h00, 8'h00,
                   rsld_pkg::GAP_END};
      queue_line(1'b0);
      settle();

      // Offset walk up to the ceiling, with no idling on either side
      stall_pct = 0;
      build_deep_line(1'b1);
      queue_line(1'b0);
      settle();
      stall_pct = 14;

      foreach (settings[i]) begin
         // register write while the block is idle
         csr_bus.valid <= 1'b1;
         csr_bus.data  <= settings[i];
         do @(posedge clock); while (!csr_bus.ready);
         copy_len = settings[i];
         csr_bus.valid <= 1'b0;

         base = bytes_queued;
         while (bytes_queued - base < PHASE_BYTES) begin
            build_line();
            queue_line($urandom_range(99) < 7);
         end
         settle();
      end

      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
